// ----- hw/rtl/rps_pkg.sv -----
// Shared types and constants for the register poll sequencer.
`default_nettype none

package rps_pkg;

  // Fixed sizes from the field definitions
  localparam int unsigned RegSlots       = 6;
  localparam int unsigned RegCount       = 8;
  localparam int unsigned RegIdxW        = 3;
  localparam int unsigned PaddrW         = 5;
  localparam int unsigned PdataW         = 32;
  localparam logic [15:0] EndMark        = 16'hFFFF;

  // Parameter defaults
  localparam int unsigned EngineCountDef = 4;
  localparam int unsigned TableSizeDef   = 6;

  // Reset values of the configuration registers
  localparam logic [7:0]  BaseAddrRst    = 8'd1;
  localparam logic [7:0]  AddrStepRst    = 8'd0;

  // Receiver status codes
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_DATA    = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_e;

  // Register map, word index
  typedef enum logic [RegIdxW-1:0] {
    REG_BASE_ADDR = 3'd0,
    REG_ADDR_STEP = 3'd1,
    REG_WANTED_0  = 3'd2,
    REG_WANTED_1  = 3'd3,
    REG_WANTED_2  = 3'd4,
    REG_WANTED_3  = 3'd5,
    REG_WANTED_4  = 3'd6,
    REG_WANTED_5  = 3'd7
  } reg_idx_e;

  // Configuration seen by the core
  typedef struct packed {
    logic [7:0]                 device_base_addr;
    logic [7:0]                 device_addr_step;
    logic [RegSlots-1:0][15:0]  wanted_reg;
  } cfg_t;

  // One poll opportunity
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] reply_value;
  } poll_req_t;

  // One result
  typedef struct packed {
    logic        request_valid;
    logic [7:0]  request_dev_addr;
    logic [15:0] request_reg_addr;
    logic        store_valid;
    logic [2:0]  store_index;
    logic [15:0] store_value;
    logic [3:0]  flag_engine;
    logic [2:0]  engine_flags;
  } poll_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/register_poll_sequencer.sv -----
// Top level of the register poll sequencer: input register, core, result register.
`default_nettype none

// Register poll sequencer. Each request on the input channel is one poll
// opportunity carrying the receiver status; each produces exactly one result
// with an optional read request, an optional stored reply and the flags of the
// engine concerned. Throughput is one request per clock while the output is not
// stalled: the polling state is updated in the single cycle in which a request
// moves from the input register to the result register, so each request passes
// through the input register and then the result register before its result
// is valid. The result register lets a new request enter while the previous
// result waits. Configuration registers are written through the APB-style port
// at byte offset 4*index and must only change while the block is idle.
module register_poll_sequencer #(
  parameter int unsigned ENGINE_COUNT = rps_pkg::EngineCountDef,
  parameter int unsigned TABLE_SIZE   = rps_pkg::TableSizeDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  rps_pkg::poll_req_t              in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output rps_pkg::poll_res_t              out_res_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rps_pkg::PaddrW-1:0] paddr,
  input  wire logic [rps_pkg::PdataW-1:0] pwdata,
  output logic      [rps_pkg::PdataW-1:0] prdata,
  output logic                            pready
);
  import rps_pkg::*;

  cfg_t      cfg;
  poll_req_t in_q;
  logic      in_valid_q;
  poll_res_t res_d, res_q;
  logic      res_valid_q;
  logic      adv;

  rps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move a request from the input register into the result register
  assign adv        = in_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  rps_core #(
    .ENGINE_COUNT (ENGINE_COUNT),
    .TABLE_SIZE   (TABLE_SIZE)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

  // A result never both issues a request and stores a reply
  a_req_xor_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.request_valid && out_res_o.store_valid))
    else $error("result carries both a request and a stored reply");

  // A request never addresses the end mark
  a_req_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.request_valid) |-> (out_res_o.request_reg_addr != EndMark))
    else $error("request issued for the table end mark");

  // Stored index stays inside the table
  a_store_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.store_valid) |-> (out_res_o.store_index < 3'(TABLE_SIZE)))
    else $error("stored index beyond table size");

  // Reported engine exists
  a_engine_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_res_o.flag_engine} < 5'(ENGINE_COUNT)))
    else $error("flag engine out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/rps_cfg_regs.sv -----
// APB-style configuration register file of the register poll sequencer.
`default_nettype none

module rps_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rps_pkg::PaddrW-1:0] paddr,
  input  wire logic [rps_pkg::PdataW-1:0] pwdata,
  output logic      [rps_pkg::PdataW-1:0] prdata,
  output logic                            pready,
  output rps_pkg::cfg_t                   cfg_o
);
  import rps_pkg::*;

  logic [7:0]                base_q;
  logic [7:0]                step_q;
  logic [RegSlots-1:0][15:0] wanted_q;
  logic                      wr_en;
  reg_idx_e                  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BaseAddrRst;
      step_q   <= AddrStepRst;
      wanted_q <= {RegSlots{EndMark}};
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE_ADDR: base_q      <= pwdata[7:0];
        REG_ADDR_STEP: step_q      <= pwdata[7:0];
        REG_WANTED_0:  wanted_q[0] <= pwdata[15:0];
        REG_WANTED_1:  wanted_q[1] <= pwdata[15:0];
        REG_WANTED_2:  wanted_q[2] <= pwdata[15:0];
        REG_WANTED_3:  wanted_q[3] <= pwdata[15:0];
        REG_WANTED_4:  wanted_q[4] <= pwdata[15:0];
        REG_WANTED_5:  wanted_q[5] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BASE_ADDR: prdata = PdataW'(base_q);
      REG_ADDR_STEP: prdata = PdataW'(step_q);
      REG_WANTED_0:  prdata = PdataW'(wanted_q[0]);
      REG_WANTED_1:  prdata = PdataW'(wanted_q[1]);
      REG_WANTED_2:  prdata = PdataW'(wanted_q[2]);
      REG_WANTED_3:  prdata = PdataW'(wanted_q[3]);
      REG_WANTED_4:  prdata = PdataW'(wanted_q[4]);
      REG_WANTED_5:  prdata = PdataW'(wanted_q[5]);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.device_base_addr = base_q;
  assign cfg_o.device_addr_step = step_q;
  assign cfg_o.wanted_reg       = wanted_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rps_core.sv -----
// Polling state and per-request sequencing logic of the register poll sequencer.
`default_nettype none

module rps_core #(
  parameter int unsigned ENGINE_COUNT = rps_pkg::EngineCountDef,
  parameter int unsigned TABLE_SIZE   = rps_pkg::TableSizeDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  rps_pkg::poll_req_t       req_i,
  input  rps_pkg::cfg_t            cfg_i,
  output rps_pkg::poll_res_t       res_o
);
  import rps_pkg::*;

  localparam int unsigned EngW = (ENGINE_COUNT > 1) ? $clog2(ENGINE_COUNT) : 1;
  localparam logic [EngW-1:0] EngLast = EngW'(ENGINE_COUNT - 1);
  localparam logic [2:0]      PosRst  = 3'(TABLE_SIZE - 1);

  logic [2:0]      pos_q, pos_d;
  logic [EngW-1:0] eng_q, eng_d, eng_inc;
  logic            wait_q, wait_d;
  logic [2:0]      flag_q [ENGINE_COUNT];
  logic [2:0]      flag_cur, flag_new;

  logic [2:0]      tbl_len;
  logic [3:0]      pos_sum;
  logic [2:0]      pos_next;
  logic [15:0]     reg_sel;
  logic [7:0]      node_addr;
  logic            is_last;

  // Table length: first end mark within the used slots
  always_comb begin
    tbl_len = 3'(TABLE_SIZE);
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (cfg_i.wanted_reg[i] == EndMark) tbl_len = 3'(i);
    end
  end

  // Next table position with wrap
  assign pos_sum  = {1'b0, pos_q} + 4'd1;
  assign pos_next = (pos_sum >= {1'b0, tbl_len}) ? 3'd0 : pos_sum[2:0];

  // Wanted register at the next position
  always_comb begin
    reg_sel = '0;
    for (int i = 0; i < RegSlots; i++) begin
      if (pos_next == 3'(i)) reg_sel = cfg_i.wanted_reg[i];
    end
  end

  // Device address of the current engine, modulo 256
  assign node_addr = cfg_i.device_base_addr + 8'(cfg_i.device_addr_step * 8'(eng_q));

  assign is_last  = (tbl_len != 3'd0) && ({1'b0, pos_q} == ({1'b0, tbl_len} - 4'd1));
  assign eng_inc  = (eng_q == EngLast) ? '0 : eng_q + 1'b1;
  assign flag_cur = flag_q[eng_q];

  // Sequencing: request, data reply or timeout
  always_comb begin
    pos_d    = pos_q;
    eng_d    = eng_q;
    wait_d   = wait_q;
    flag_new = flag_cur;
    res_o    = '0;
    if (!wait_q) begin
      if (tbl_len != 3'd0) begin
        pos_d                  = pos_next;
        wait_d                 = 1'b1;
        res_o.request_valid    = 1'b1;
        res_o.request_dev_addr = node_addr;
        res_o.request_reg_addr = reg_sel;
      end
    end else begin
      case (action_e'(req_i.action))
        ACT_DATA: begin
          res_o.store_valid = 1'b1;
          res_o.store_index = pos_q;
          res_o.store_value = req_i.reply_value;
          flag_new[0]       = 1'b1;
          if (is_last) begin
            flag_new[1] = 1'b1;
            eng_d       = eng_inc;
          end
          wait_d = 1'b0;
        end
        ACT_TIMEOUT: begin
          flag_new[2] = 1'b1;
          eng_d       = eng_inc;
          wait_d      = 1'b0;
        end
        default: ;
      endcase
    end
    res_o.flag_engine  = 4'(eng_q);
    res_o.engine_flags = flag_new;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosRst;
      eng_q  <= '0;
      wait_q <= 1'b0;
      for (int i = 0; i < ENGINE_COUNT; i++) flag_q[i] <= '0;
    end else if (adv_i) begin
      pos_q          <= pos_d;
      eng_q          <= eng_d;
      wait_q         <= wait_d;
      flag_q[eng_q]  <= flag_new;
    end
  end

endmodule

`default_nettype wire
